[rtl/field_slice_energy_assert.svh]
// Assertion macros for the field_slice_energy RTL.
// Included by fse_ctrl, which checks its own control logic; needs no package.
`ifndef FIELD_SLICE_ENERGY_ASSERT_SVH
`define FIELD_SLICE_ENERGY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("field_slice_energy: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("field_slice_energy: next-cycle check failed");

`endif

[rtl/fse_pkg.sv]
// Package for the field slice energy block: widths, codes, reset values and
// the command and status types between controller and datapath. No dependencies.
package fse_pkg;

   // Field and coefficient widths.
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SUM_BITS       = 48;
   localparam int PHI_OUT_BITS   = 47;
   localparam int HALF_SUM_BITS  = SUM_BITS / 2;
   localparam int REQ_DATA_BITS  = 4 * SAMPLE_BITS;
   localparam int RSP_DATA_BITS  = ((PHI_OUT_BITS + SUM_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - PHI_OUT_BITS - SUM_BITS;

   // Shared multiplier and its holding registers.
   localparam int MUL_A_BITS = 37;
   localparam int MUL_B_BITS = COEF_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int ACC_BITS   = 42;
   localparam int FRAC_BITS  = 12;
   localparam int WIDE_BITS  = PROD_BITS + FRAC_BITS;

   // Derivative rounding from Q12.20 to Q4.12.
   localparam int DERIV_SHIFT = 8;
   localparam int ROUND_HALF  = 128;

   typedef logic signed [SAMPLE_BITS-1:0] fse_sample_type;
   typedef logic [COEF_BITS-1:0]          fse_coef_type;
   typedef logic signed [COEF_BITS-1:0]   fse_weight_type;
   typedef logic signed [MUL_A_BITS-1:0]  fse_mul_a_type;
   typedef logic signed [MUL_B_BITS-1:0]  fse_mul_b_type;
   typedef logic signed [PROD_BITS-1:0]   fse_prod_type;
   typedef logic signed [ACC_BITS-1:0]    fse_acc_type;
   typedef logic signed [SUM_BITS-1:0]    fse_sum_type;
   typedef logic signed [WIDE_BITS-1:0]   fse_wide_type;
   typedef logic [1:0]                    fse_fill_type;
   typedef logic [CSR_INDEX_BITS-1:0]     fse_csr_index_type;

   localparam fse_sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam fse_sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam fse_sum_type    SUM_MAX    = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam fse_sum_type    SUM_MIN    = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam fse_fill_type   WINDOW_FULL = 2'd2;

   // Register indexes on the configuration port.
   localparam fse_csr_index_type CSR_GRID_STEP    = 3'd0;
   localparam fse_csr_index_type CSR_INV_TWO_STEP = 3'd1;
   localparam fse_csr_index_type CSR_PHI_MASS_SQ  = 3'd2;
   localparam fse_csr_index_type CSR_CHI_MASS_SQ  = 3'd3;
   localparam fse_csr_index_type CSR_GHOST_WEIGHT = 3'd4;

   // Register reset values.
   localparam fse_coef_type   GRID_STEP_RESET    = 16'd256;
   localparam fse_coef_type   INV_TWO_STEP_RESET = 16'd2048;
   localparam fse_weight_type GHOST_RESET        = 16'sd4096;
   localparam fse_weight_type UNIT_WEIGHT        = 16'sd4096;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIFF,
      ST_RATE,
      ST_DSQ,
      ST_SSQ,
      ST_MASS,
      ST_ENERGY,
      ST_WEIGHT,
      ST_ACCUM,
      ST_SHIFT,
      ST_OUT_HI,
      ST_OUT_LO,
      ST_OUT_FIN
   } fse_state_type;

   // Operations issued to both field lanes.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_DIFF,
      OP_RATE,
      OP_DSQ,
      OP_SSQ,
      OP_MASS,
      OP_ENERGY,
      OP_WEIGHT,
      OP_ACCUM,
      OP_SHIFT,
      OP_OUT_HI,
      OP_OUT_LO
   } fse_op_type;

   typedef struct packed {
      fse_op_type op;
      logic       capture;
      logic       load_out;
   } fse_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic full;
      logic out_busy;
   } fse_status_type;

endpackage

[rtl/fse_lane.sv]
// One field lane: three-point window, shared multiplier, energy accumulation
// and the scaled result. Depends on fse_pkg.
module fse_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  fse_pkg::fse_op_type     op,
   input  fse_pkg::fse_sample_type next_sample,
   input  fse_pkg::fse_sample_type next_rate,
   input  fse_pkg::fse_coef_type   inv_two_step,
   input  fse_pkg::fse_coef_type   mass_sq,
   input  fse_pkg::fse_coef_type   grid_step,
   input  fse_pkg::fse_weight_type weight,
   output fse_pkg::fse_sum_type    result
);

   fse_pkg::fse_sample_type back_one_ff, back_one_in;
   fse_pkg::fse_sample_type back_two_ff, back_two_in;
   fse_pkg::fse_sample_type mid_rate_ff, mid_rate_in;
   fse_pkg::fse_sample_type d_ff, d_in;
   fse_pkg::fse_prod_type   prod_ff, prod_in;
   fse_pkg::fse_acc_type    acc_ff, acc_in;
   fse_pkg::fse_sum_type    sum_ff, sum_in;

   logic signed [fse_pkg::SAMPLE_BITS:0] diff;
   fse_pkg::fse_mul_a_type mul_a;
   fse_pkg::fse_mul_b_type mul_b;
   fse_pkg::fse_prod_type  product;
   fse_pkg::fse_prod_type  rounded;
   fse_pkg::fse_sample_type deriv_sat;
   fse_pkg::fse_prod_type  energy_sum;
   fse_pkg::fse_prod_type  sum_total;
   fse_pkg::fse_sum_type   sum_sat;
   fse_pkg::fse_wide_type  wide;
   fse_pkg::fse_wide_type  wide_shift;

   // Central difference numerator, one bit wider than a sample.
   assign diff = {next_sample[fse_pkg::SAMPLE_BITS-1], next_sample}
               - {back_two_ff[fse_pkg::SAMPLE_BITS-1], back_two_ff};

   // Operand selection for the lane multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op)
         fse_pkg::OP_DIFF: begin
            mul_a = fse_pkg::fse_mul_a_type'(diff);
            mul_b = fse_pkg::fse_mul_b_type'($signed({1'b0, inv_two_step}));
         end
         fse_pkg::OP_RATE: begin
            mul_a = fse_pkg::fse_mul_a_type'(mid_rate_ff);
            mul_b = fse_pkg::fse_mul_b_type'(mid_rate_ff);
         end
         fse_pkg::OP_DSQ: begin
            mul_a = fse_pkg::fse_mul_a_type'(d_ff);
            mul_b = fse_pkg::fse_mul_b_type'(d_ff);
         end
         fse_pkg::OP_SSQ: begin
            mul_a = fse_pkg::fse_mul_a_type'(back_one_ff);
            mul_b = fse_pkg::fse_mul_b_type'(back_one_ff);
         end
         fse_pkg::OP_MASS: begin
            // The sample square is non-negative and below 2^31.
            mul_a = fse_pkg::fse_mul_a_type'(prod_ff[fse_pkg::MUL_A_BITS-2:0]);
            mul_b = fse_pkg::fse_mul_b_type'($signed({1'b0, mass_sq}));
         end
         fse_pkg::OP_WEIGHT: begin
            // The point energy is non-negative and below 2^36.
            mul_a = fse_pkg::fse_mul_a_type'(acc_ff[fse_pkg::MUL_A_BITS-2:0]);
            mul_b = fse_pkg::fse_mul_b_type'(weight);
         end
         fse_pkg::OP_OUT_HI: begin
            mul_a = fse_pkg::fse_mul_a_type'(
               $signed(sum_ff[fse_pkg::SUM_BITS-1:fse_pkg::HALF_SUM_BITS]));
            mul_b = fse_pkg::fse_mul_b_type'($signed({1'b0, grid_step}));
         end
         fse_pkg::OP_OUT_LO: begin
            mul_a = fse_pkg::fse_mul_a_type'(sum_ff[fse_pkg::HALF_SUM_BITS-1:0]);
            mul_b = fse_pkg::fse_mul_b_type'($signed({1'b0, grid_step}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // Round the scaled difference to Q4.12 and clamp it to the sample range.
   assign rounded = (prod_ff + fse_pkg::fse_prod_type'(fse_pkg::ROUND_HALF))
                  >>> fse_pkg::DERIV_SHIFT;

   always_comb begin
      if (rounded > fse_pkg::fse_prod_type'(fse_pkg::SAMPLE_MAX)) begin
         deriv_sat = fse_pkg::SAMPLE_MAX;
      end else if (rounded < fse_pkg::fse_prod_type'(fse_pkg::SAMPLE_MIN)) begin
         deriv_sat = fse_pkg::SAMPLE_MIN;
      end else begin
         deriv_sat = fse_pkg::fse_sample_type'(rounded);
      end
   end

   // Half of the squares plus the scaled mass term.
   assign energy_sum = fse_pkg::fse_prod_type'(acc_ff) + (prod_ff >>> fse_pkg::FRAC_BITS);

   // Saturating accumulation of the weighted point energy.
   assign sum_total = fse_pkg::fse_prod_type'(sum_ff) + (prod_ff >>> fse_pkg::FRAC_BITS);

   always_comb begin
      if (sum_total > fse_pkg::fse_prod_type'(fse_pkg::SUM_MAX)) begin
         sum_sat = fse_pkg::SUM_MAX;
      end else if (sum_total < fse_pkg::fse_prod_type'(fse_pkg::SUM_MIN)) begin
         sum_sat = fse_pkg::SUM_MIN;
      end else begin
         sum_sat = fse_pkg::fse_sum_type'(sum_total);
      end
   end

   // Grid step times the sum: upper partial product in acc, lower in prod.
   assign wide = (fse_pkg::fse_wide_type'(acc_ff) <<< fse_pkg::HALF_SUM_BITS)
               + fse_pkg::fse_wide_type'(prod_ff);
   assign wide_shift = wide >>> fse_pkg::FRAC_BITS;

   always_comb begin
      if (wide_shift > fse_pkg::fse_wide_type'(fse_pkg::SUM_MAX)) begin
         result = fse_pkg::SUM_MAX;
      end else if (wide_shift < fse_pkg::fse_wide_type'(fse_pkg::SUM_MIN)) begin
         result = fse_pkg::SUM_MIN;
      end else begin
         result = fse_pkg::fse_sum_type'(wide_shift);
      end
   end

   // Next values of the lane registers for each operation.
   always_comb begin
      back_one_in = back_one_ff;
      back_two_in = back_two_ff;
      mid_rate_in = mid_rate_ff;
      d_in        = d_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      sum_in      = sum_ff;
      case (op) inside
         fse_pkg::OP_CLEAR: begin
            back_one_in = '0;
            back_two_in = '0;
            mid_rate_in = '0;
            sum_in      = '0;
         end
         fse_pkg::OP_DIFF, fse_pkg::OP_MASS, fse_pkg::OP_WEIGHT,
         fse_pkg::OP_OUT_HI: begin
            prod_in = product;
         end
         fse_pkg::OP_RATE: begin
            prod_in = product;
            d_in    = deriv_sat;
         end
         fse_pkg::OP_DSQ: begin
            prod_in = product;
            acc_in  = fse_pkg::fse_acc_type'(prod_ff);
         end
         fse_pkg::OP_SSQ: begin
            prod_in = product;
            acc_in  = acc_ff + fse_pkg::fse_acc_type'(prod_ff);
         end
         fse_pkg::OP_ENERGY: begin
            acc_in = fse_pkg::fse_acc_type'(energy_sum >>> 1);
         end
         fse_pkg::OP_ACCUM: begin
            sum_in      = sum_sat;
            back_two_in = back_one_ff;
            back_one_in = next_sample;
            mid_rate_in = next_rate;
         end
         fse_pkg::OP_SHIFT: begin
            back_two_in = back_one_ff;
            back_one_in = next_sample;
            mid_rate_in = next_rate;
         end
         fse_pkg::OP_OUT_LO: begin
            prod_in = product;
            acc_in  = fse_pkg::fse_acc_type'(prod_ff);
         end
         default: begin
         end
      endcase
   end

   // Window and sum: cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         back_one_ff <= '0;
         back_two_ff <= '0;
         mid_rate_ff <= '0;
         sum_ff      <= '0;
      end else begin
         back_one_ff <= back_one_in;
         back_two_ff <= back_two_in;
         mid_rate_ff <= mid_rate_in;
         sum_ff      <= sum_in;
      end
   end

   // Working registers of the multiplier sequence.
   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

[rtl/fse_ctrl.sv]
// Controller of the field slice energy block: walks each item through the
// multiplier sequence and the result handoff. Depends on fse_pkg and the assert header.
`include "field_slice_energy_assert.svh"

module fse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  fse_pkg::fse_status_type status,
   output fse_pkg::fse_cmd_type    cmd
);

   fse_pkg::fse_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         fse_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = fse_pkg::ST_START;
            end
         end
         fse_pkg::ST_START: begin
            if (status.full && !status.first) begin
               state_in = fse_pkg::ST_DIFF;
            end else begin
               state_in = fse_pkg::ST_SHIFT;
            end
         end
         fse_pkg::ST_DIFF:   state_in = fse_pkg::ST_RATE;
         fse_pkg::ST_RATE:   state_in = fse_pkg::ST_DSQ;
         fse_pkg::ST_DSQ:    state_in = fse_pkg::ST_SSQ;
         fse_pkg::ST_SSQ:    state_in = fse_pkg::ST_MASS;
         fse_pkg::ST_MASS:   state_in = fse_pkg::ST_ENERGY;
         fse_pkg::ST_ENERGY: state_in = fse_pkg::ST_WEIGHT;
         fse_pkg::ST_WEIGHT: state_in = fse_pkg::ST_ACCUM;
         fse_pkg::ST_ACCUM, fse_pkg::ST_SHIFT: begin
            if (status.last) begin
               state_in = fse_pkg::ST_OUT_HI;
            end else begin
               state_in = fse_pkg::ST_IDLE;
            end
         end
         fse_pkg::ST_OUT_HI: state_in = fse_pkg::ST_OUT_LO;
         fse_pkg::ST_OUT_LO: state_in = fse_pkg::ST_OUT_FIN;
         fse_pkg::ST_OUT_FIN: begin
            if (!status.out_busy) begin
               state_in = fse_pkg::ST_IDLE;
            end
         end
         default: state_in = fse_pkg::ST_IDLE;
      endcase
   end

   // Outputs per state.
   always_comb begin
      req_tready   = 1'b0;
      cmd.op       = fse_pkg::OP_NONE;
      cmd.capture  = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         fse_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         fse_pkg::ST_START: begin
            if (status.first) begin
               cmd.op = fse_pkg::OP_CLEAR;
            end
         end
         fse_pkg::ST_DIFF:   cmd.op = fse_pkg::OP_DIFF;
         fse_pkg::ST_RATE:   cmd.op = fse_pkg::OP_RATE;
         fse_pkg::ST_DSQ:    cmd.op = fse_pkg::OP_DSQ;
         fse_pkg::ST_SSQ:    cmd.op = fse_pkg::OP_SSQ;
         fse_pkg::ST_MASS:   cmd.op = fse_pkg::OP_MASS;
         fse_pkg::ST_ENERGY: cmd.op = fse_pkg::OP_ENERGY;
         fse_pkg::ST_WEIGHT: cmd.op = fse_pkg::OP_WEIGHT;
         fse_pkg::ST_ACCUM:  cmd.op = fse_pkg::OP_ACCUM;
         fse_pkg::ST_SHIFT:  cmd.op = fse_pkg::OP_SHIFT;
         fse_pkg::ST_OUT_HI: cmd.op = fse_pkg::OP_OUT_HI;
         fse_pkg::ST_OUT_LO: cmd.op = fse_pkg::OP_OUT_LO;
         fse_pkg::ST_OUT_FIN: begin
            // Hand the result over and start the next slice fresh.
            if (!status.out_busy) begin
               cmd.op       = fse_pkg::OP_CLEAR;
               cmd.load_out = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A held result is never overwritten.
   `FSE_ASSERT_IMPL(a_load_when_free, clock, reset, cmd.load_out, !status.out_busy)
   // The derivative step only runs on a filled window.
   `FSE_ASSERT_IMPL(a_diff_needs_window, clock, reset, state_ff == fse_pkg::ST_DIFF, $past(status.full))
   // Output steps only follow an item marked last.
   `FSE_ASSERT_IMPL(a_out_after_last, clock, reset, state_ff == fse_pkg::ST_OUT_HI, $past(status.last))
   // One item at a time.
   `FSE_ASSERT_NEXT(a_single_item, clock, reset, cmd.capture, !req_tready)

endmodule

[rtl/fse_datapath.sv]
// Datapath of the field slice energy block: configuration registers, item
// capture, window fill count, the two field lanes and the result register.
// Depends on fse_pkg and fse_lane.
module fse_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fse_pkg::fse_cmd_type                cmd,
   output fse_pkg::fse_status_type             status,
   input  logic [fse_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [0:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fse_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_wr_en,
   input  fse_pkg::fse_csr_index_type          csr_index,
   input  logic [fse_pkg::COEF_BITS-1:0]       csr_wdata
);

   localparam int SB = fse_pkg::SAMPLE_BITS;

   fse_pkg::fse_coef_type   grid_step_ff, grid_step_in;
   fse_pkg::fse_coef_type   inv_two_step_ff, inv_two_step_in;
   fse_pkg::fse_coef_type   phi_mass_sq_ff, phi_mass_sq_in;
   fse_pkg::fse_coef_type   chi_mass_sq_ff, chi_mass_sq_in;
   fse_pkg::fse_weight_type ghost_weight_ff, ghost_weight_in;

   fse_pkg::fse_sample_type phi_sample_ff, phi_rate_ff, chi_sample_ff, chi_rate_ff;
   logic                    first_ff, last_ff;
   fse_pkg::fse_fill_type   fill_ff, fill_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [fse_pkg::PHI_OUT_BITS-1:0]    rsp_phi_ff;
   fse_pkg::fse_sum_type                rsp_chi_ff;
   fse_pkg::fse_sum_type                phi_result, chi_result;

   // Configuration register decode.
   always_comb begin
      grid_step_in    = grid_step_ff;
      inv_two_step_in = inv_two_step_ff;
      phi_mass_sq_in  = phi_mass_sq_ff;
      chi_mass_sq_in  = chi_mass_sq_ff;
      ghost_weight_in = ghost_weight_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fse_pkg::CSR_GRID_STEP:    grid_step_in    = csr_wdata;
            fse_pkg::CSR_INV_TWO_STEP: inv_two_step_in = csr_wdata;
            fse_pkg::CSR_PHI_MASS_SQ:  phi_mass_sq_in  = csr_wdata;
            fse_pkg::CSR_CHI_MASS_SQ:  chi_mass_sq_in  = csr_wdata;
            fse_pkg::CSR_GHOST_WEIGHT: ghost_weight_in = $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_step_ff    <= fse_pkg::GRID_STEP_RESET;
         inv_two_step_ff <= fse_pkg::INV_TWO_STEP_RESET;
         phi_mass_sq_ff  <= '0;
         chi_mass_sq_ff  <= '0;
         ghost_weight_ff <= fse_pkg::GHOST_RESET;
      end else begin
         grid_step_ff    <= grid_step_in;
         inv_two_step_ff <= inv_two_step_in;
         phi_mass_sq_ff  <= phi_mass_sq_in;
         chi_mass_sq_ff  <= chi_mass_sq_in;
         ghost_weight_ff <= ghost_weight_in;
      end
   end

   // Item capture; held while the item is worked on.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         phi_sample_ff <= $signed(req_tdata[SB-1:0]);
         phi_rate_ff   <= $signed(req_tdata[2*SB-1:SB]);
         chi_sample_ff <= $signed(req_tdata[3*SB-1:2*SB]);
         chi_rate_ff   <= $signed(req_tdata[4*SB-1:3*SB]);
         first_ff      <= req_tuser[0];
         last_ff       <= req_tlast;
      end
   end

   // Window fill count, shared by both lanes.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.op == fse_pkg::OP_CLEAR) begin
         fill_in = '0;
      end else if ((cmd.op == fse_pkg::OP_SHIFT || cmd.op == fse_pkg::OP_ACCUM)
                   && fill_ff != fse_pkg::WINDOW_FULL) begin
         fill_in = fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Phi lane carries unit weight, so its sum stays the plain energy sum.
   fse_lane u_phi_lane (
      .clock        (clock),
      .reset        (reset),
      .op           (cmd.op),
      .next_sample  (phi_sample_ff),
      .next_rate    (phi_rate_ff),
      .inv_two_step (inv_two_step_ff),
      .mass_sq      (phi_mass_sq_ff),
      .grid_step    (grid_step_ff),
      .weight       (fse_pkg::UNIT_WEIGHT),
      .result       (phi_result)
   );

   fse_lane u_chi_lane (
      .clock        (clock),
      .reset        (reset),
      .op           (cmd.op),
      .next_sample  (chi_sample_ff),
      .next_rate    (chi_rate_ff),
      .inv_two_step (inv_two_step_ff),
      .mass_sq      (chi_mass_sq_ff),
      .grid_step    (grid_step_ff),
      .weight       (ghost_weight_ff),
      .result       (chi_result)
   );

   // Result register: holds one item until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The phi result is never negative, so its low bits are the whole value.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_phi_ff <= phi_result[fse_pkg::PHI_OUT_BITS-1:0];
         rsp_chi_ff <= chi_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{fse_pkg::RSP_PAD_BITS{1'b0}}, rsp_chi_ff, rsp_phi_ff};

   // Status toward the controller.
   assign status.first    = first_ff;
   assign status.last     = last_ff;
   assign status.full     = (fill_ff == fse_pkg::WINDOW_FULL);
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

endmodule

[rtl/field_slice_energy.sv]
// Top level of the field slice energy block: joins controller and datapath.
// Depends on fse_pkg, fse_ctrl, fse_datapath and fse_lane.
//
// Use: grid points of one time slice arrive in order on the req_ stream.
// tuser marks the left boundary point (window and sums clear first) and
// tlast the right one; after the last item one result leaves on rsp_ with
// grid_step times the phi energy sum and the weighted chi energy sum.
// Coefficients are to be written through csr_ only while the block is idle;
// the block itself does not enforce this. Throughput: one item at a time.
// An item that finds fewer than two points in the window only shifts it in;
// one with a full window runs the eight-step sequence of the one multiplier
// in each field lane (difference, three squares, mass term, energy, weight,
// accumulate). Output: after the last item the steps OUT_HI and OUT_LO form
// the two partial products of the output scaling and OUT_FIN loads the result
// once the output register is free; rsp_tvalid rises as the controller returns
// to idle, so the next item can be taken in that same cycle.
// Reset: synchronous, clears window, sums and result, and restores the
// coefficient defaults. A stalled receiver holds the result in the output
// register; items keep being taken until a next result would need it.
module field_slice_energy (
   input  logic                              clock,
   input  logic                              reset,
   // Fields from bit 0: phi_sample, phi_rate, chi_sample, chi_rate.
   input  logic [fse_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // Fields from bit 0: is_first.
   input  logic [0:0]                        req_tuser,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: phi_energy (47 bits), chi_energy (48 bits), one zero bit.
   output logic [fse_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  fse_pkg::fse_csr_index_type        csr_index,
   input  logic [fse_pkg::COEF_BITS-1:0]     csr_wdata
);

   fse_pkg::fse_cmd_type    cmd;
   fse_pkg::fse_status_type status;

   fse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fse_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

[sim/fse_checker.sv]
// Checker for the field slice energy block: follows coefficient writes and accepted items,
// predicts the per-slice energy results and compares them with the rsp_ stream.
// Depends on fse_pkg for widths, register indexes and reset values.
`timescale 1ns / 100ps

module fse_checker
   import fse_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [0:0]               req_tuser,
   input  logic                     req_tlast,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_wr_en,
   input  fse_csr_index_type        csr_index,
   input  logic [COEF_BITS-1:0]     csr_wdata,
   output int                       fail_count,
   output int                       pending_results,
   output int                       results_seen
);

   typedef struct packed {
      logic [PHI_OUT_BITS-1:0] phi_energy;
      logic [SUM_BITS-1:0]     chi_energy;
   } slice_energy_type;

   // Saturation bounds of the sums and caps of the intermediate terms.
   localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF;
   localparam longint ACC_MIN      = -ACC_MAX - 1;
   localparam longint TERM_LIMIT   = 64'sh1_0000_0000_0000;
   localparam longint ENERGY_LIMIT = 64'sh8000_0000_0000;

   // Coefficients as last written.
   fse_coef_type   step_cfg;
   fse_coef_type   inv_cfg;
   fse_coef_type   phi_mass_cfg;
   fse_coef_type   chi_mass_cfg;
   fse_weight_type ghost_cfg;

   // Three-point window and running sums.
   fse_sample_type phi_one, phi_two, chi_one, chi_two;
   fse_sample_type phi_rate_mid, chi_rate_mid;
   fse_fill_type   fill;
   longint         phi_acc, chi_acc;

   slice_energy_type energy_queue[$];
   int               mismatches = 0;
   int               results_count = 0;

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_seen    = 0;
   end

   function automatic longint clamp(longint value, longint lo, longint hi);
      if (value > hi) return hi;
      if (value < lo) return lo;
      return value;
   endfunction

   // Central difference in Q4.12, rounded from Q12.20 and saturated to a sample.
   function automatic longint central_diff(longint prev, longint next);
      longint d;
      d = ((next - prev) * longint'(inv_cfg) + 128) >>> 8;
      return clamp(d, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX));
   endfunction

   // Half of rate squared, slope squared and mass term, all in Q8.24.
   function automatic longint point_energy(longint sample, longint rate, longint d,
                                           longint mass);
      longint s2, term, e;
      s2   = sample * sample;
      term = (s2 >>> 12) * mass + (((s2 % 4096) * mass) >>> 12);
      if (term > TERM_LIMIT) term = TERM_LIMIT;
      e = (rate * rate + d * d + term) >>> 1;
      if (e > ENERGY_LIMIT) e = ENERGY_LIMIT;
      return e;
   endfunction

   function automatic void clear_slice();
      phi_one      = '0;
      phi_two      = '0;
      chi_one      = '0;
      chi_two      = '0;
      phi_rate_mid = '0;
      chi_rate_mid = '0;
      fill         = '0;
      phi_acc      = 0;
      chi_acc      = 0;
   endfunction

   // Takes one grid point; a last marker queues the scaled sums of the slice.
   function automatic void take_point(fse_sample_type phi, fse_sample_type phr,
                                      fse_sample_type chi, fse_sample_type chr,
                                      logic first, logic last);
      longint dp, dc, ep, ec, wc, p, c;
      slice_energy_type result;
      if (first) clear_slice();
      if (fill == WINDOW_FULL) begin
         dp = central_diff(phi_two, phi);
         dc = central_diff(chi_two, chi);
         ep = point_energy(phi_one, phi_rate_mid, dp, longint'(phi_mass_cfg));
         ec = point_energy(chi_one, chi_rate_mid, dc, longint'(chi_mass_cfg));
         wc = (longint'(ghost_cfg) * ec) >>> 12;
         phi_acc = clamp(phi_acc + ep, 0, ACC_MAX);
         chi_acc = clamp(chi_acc + wc, ACC_MIN, ACC_MAX);
      end
      phi_two      = phi_one;
      chi_two      = chi_one;
      phi_one      = phi;
      chi_one      = chi;
      phi_rate_mid = phr;
      chi_rate_mid = chr;
      if (fill != WINDOW_FULL) fill = fill + 1'b1;
      if (last) begin
         p = clamp((phi_acc * longint'(step_cfg)) >>> 12, 0, ACC_MAX);
         c = clamp((chi_acc * longint'(step_cfg)) >>> 12, ACC_MIN, ACC_MAX);
         result.phi_energy = p[PHI_OUT_BITS-1:0];
         result.chi_energy = c[SUM_BITS-1:0];
         energy_queue.push_back(result);
         clear_slice();
      end
   endfunction

   // Compares one accepted result with the oldest predicted one, field by field.
   function automatic void check_result();
      slice_energy_type   want;
      logic [PHI_OUT_BITS-1:0] got_phi;
      logic [SUM_BITS-1:0]     got_chi;
      logic [RSP_PAD_BITS-1:0] got_pad;
      got_phi = rsp_tdata[PHI_OUT_BITS-1:0];
      got_chi = rsp_tdata[PHI_OUT_BITS +: SUM_BITS];
      got_pad = rsp_tdata[RSP_DATA_BITS-1 -: RSP_PAD_BITS];
      results_count++;
      if (energy_queue.size() == 0) begin
         $display("%0t: result with none expected, got phi_energy %0d chi_energy %0d",
                  $time, got_phi, $signed(got_chi));
         mismatches++;
         return;
      end
      want = energy_queue.pop_front();
      if (got_phi !== want.phi_energy) begin
         $display("%0t: phi_energy mismatch, expected %0d, got %0d",
                  $time, want.phi_energy, got_phi);
         mismatches++;
      end
      if (got_chi !== want.chi_energy) begin
         $display("%0t: chi_energy mismatch, expected %0d, got %0d",
                  $time, $signed(want.chi_energy), $signed(got_chi));
         mismatches++;
      end
      if (got_pad !== '0) begin
         $display("%0t: padding bits mismatch, expected 0, got %b", $time, got_pad);
         mismatches++;
      end
   endfunction

   // Everything is sampled at the rising edge; the counts reach the top as registered outputs.
   always @(posedge clock) begin
      if (reset) begin
         step_cfg     = GRID_STEP_RESET;
         inv_cfg      = INV_TWO_STEP_RESET;
         phi_mass_cfg = '0;
         chi_mass_cfg = '0;
         ghost_cfg    = GHOST_RESET;
         clear_slice();
         energy_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GRID_STEP:    step_cfg = csr_wdata;
               CSR_INV_TWO_STEP: inv_cfg = csr_wdata;
               CSR_PHI_MASS_SQ:  phi_mass_cfg = csr_wdata;
               CSR_CHI_MASS_SQ:  chi_mass_cfg = csr_wdata;
               CSR_GHOST_WEIGHT: ghost_cfg = fse_weight_type'(csr_wdata);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            take_point(req_tdata[0 +: SAMPLE_BITS], req_tdata[SAMPLE_BITS +: SAMPLE_BITS],
                       req_tdata[2*SAMPLE_BITS +: SAMPLE_BITS],
                       req_tdata[3*SAMPLE_BITS +: SAMPLE_BITS], req_tuser[0], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
      fail_count      <= mismatches;
      pending_results <= energy_queue.size();
      results_seen    <= results_count;
   end

endmodule

[sim/tb_top.sv]
// Top of the field slice energy testbench: clock, reset, stimulus and verdict.
// Depends on fse_pkg, the field_slice_energy RTL and the fse_checker module.
`timescale 1ns / 100ps

module tb_top;
   import fse_pkg::*;

   localparam int CYCLE_LIMIT  = 100_000;
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 12;

   logic                     clock;
   logic                     reset = 1'b1;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [0:0]               req_tuser = '0;
   logic                     req_tlast = 1'b0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_wr_en = 1'b0;
   fse_csr_index_type        csr_index = CSR_GRID_STEP;
   logic [COEF_BITS-1:0]     csr_wdata = '0;

   logic idle_enable = 1'b0;
   int   items_sent = 0;
   int   settings_used = 1;
   int   cycle_count = 0;
   int   stall_left = 0;
   int   fail_count, pending_results, results_seen;

   field_slice_energy uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   fse_checker energy_check (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_seen    (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver stalls come in bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Run timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Samples lean toward the extremes, zero and small values.
   function automatic fse_sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return fse_sample_type'($urandom_range(0, 8)) - 16'sd4;
         default: return fse_sample_type'($urandom);
      endcase
   endfunction

   function automatic fse_coef_type pick_coef();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 16'h8000;
         3: return fse_coef_type'($urandom_range(0, 8192));
         default: return fse_coef_type'($urandom);
      endcase
   endfunction

   // Drives one item and returns at the edge where it is accepted.
   task automatic send_point(fse_sample_type phi, fse_sample_type phr, fse_sample_type chi,
                             fse_sample_type chr, logic first, logic last);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tdata  <= {chr, chi, phr, phi};
      req_tuser  <= first;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_random_point(logic first, logic last);
      send_point(pick_sample(), pick_sample(), pick_sample(), pick_sample(), first, last);
   endtask

   // Writes all five coefficients on consecutive edges.
   task automatic set_coefs(fse_coef_type grid, fse_coef_type inv, fse_coef_type phi_mass,
                            fse_coef_type chi_mass, fse_coef_type ghost);
      fse_csr_index_type idx[5];
      fse_coef_type      val[5];
      idx = '{CSR_GRID_STEP, CSR_INV_TWO_STEP, CSR_PHI_MASS_SQ, CSR_CHI_MASS_SQ,
              CSR_GHOST_WEIGHT};
      val = '{grid, inv, phi_mass, chi_mass, ghost};
      csr_wr_en <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Waits until every result is in, then lets the block settle before a write.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Long slice at full amplitude: pairs of equal samples keep the slope at its limit,
   // so the weighted chi result runs past the output range.
   task automatic send_long_slice(int count);
      fse_sample_type level;
      for (int i = 0; i < count; i++) begin
         level = ((i / 2) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
         send_point(level, SAMPLE_MIN, level, SAMPLE_MIN, i == 0, i == count - 1);
      end
   endtask

   // One random slice: well-formed, without a first marker, or loose noise flags.
   task automatic send_random_slice(ref int budget);
      int len;
      int shape;
      shape = $urandom_range(0, 9);
      len   = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         if (shape == 0)
            send_random_point($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
         else if (shape == 1)
            send_random_point(1'b0, i == len - 1);
         else
            send_random_point(i == 0, i == len - 1);
      end
      budget -= len;
   endtask

   initial begin
      int budget;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients: extremes of every field, both markers, short slices.
      send_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0);
      send_point(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b0);
      send_point(SAMPLE_MAX, '0, SAMPLE_MIN, 16'sd1, 1'b0, 1'b0);
      send_point('0, SAMPLE_MIN, '0, SAMPLE_MAX, 1'b0, 1'b1);
      send_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b1);
      send_point(16'sd4096, 16'sd4096, -16'sd4096, 16'sd4096, 1'b1, 1'b0);
      send_point(-16'sd1, 16'sd1, 16'sd1, -16'sd1, 1'b0, 1'b1);
      // Slice with no first marker after a result.
      send_point(16'sd100, 16'sd200, -16'sd300, 16'sd400, 1'b0, 1'b0);
      send_point(SAMPLE_MIN, 16'sd7, SAMPLE_MAX, -16'sd7, 1'b0, 1'b0);
      send_point(SAMPLE_MAX, -16'sd2, SAMPLE_MIN, 16'sd2, 1'b0, 1'b0);
      send_point(16'sd5, SAMPLE_MAX, -16'sd5, SAMPLE_MIN, 1'b0, 1'b1);
      // Lone last marker, then a first marker in the middle of a slice.
      send_point(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b1);
      send_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0);
      send_point(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b0);
      send_point(16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000, 1'b1, 1'b0);
      send_point(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0);
      send_point(SAMPLE_MAX, '0, SAMPLE_MIN, '0, 1'b0, 1'b1);
      wait_drained();

      // Largest coefficients, then smallest with the most negative weight.
      set_coefs('1, '1, '1, '1, 16'h7FFF);
      send_point(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0);
      send_point(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b0);
      send_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0);
      send_point(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b1);
      wait_drained();
      set_coefs('0, '0, '0, '0, 16'h8000);
      send_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b0);
      send_point(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0);
      send_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b1);
      wait_drained();

      // Long slices drive the chi result to the low and the high output limit.
      set_coefs('1, '1, '1, '1, 16'h8000);
      send_long_slice(130);
      wait_drained();
      set_coefs('1, '1, '1, '1, 16'h7FFF);
      send_long_slice(130);
      wait_drained();

      // Random phases, each under its own coefficients; phase 2 and the last two run without idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
         idle_enable <= (phase < PHASES - 2) && (phase != 2);
         budget = PHASE_ITEMS;
         while (budget > 0) send_random_slice(budget);
         send_random_point($urandom_range(0, 1) == 1, 1'b1);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items under %0d coefficient settings; %0d slice results checked.",
               items_sent, settings_used, results_seen);
      $display("Covered boundary markers, short and unmarked slices, and clipped results.");
      if (fail_count == 0 && pending_results == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/fse_pkg.sv
rtl/fse_lane.sv
rtl/fse_ctrl.sv
rtl/fse_datapath.sv
rtl/field_slice_energy.sv
sim/fse_checker.sv
sim/tb_top.sv
